>>> design/tfdc_pkg.sv
// Package with the shared types, constants and duty tables of the thermal fan duty controller.
`default_nettype none

package tfdc_pkg;

  localparam int TEMP_W  = 19;
  localparam int MASK_W  = 4;
  localparam int DUTY_W  = 7;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [DUTY_W-1:0] duty_t;

  typedef enum logic [1:0] {
    LVL_LOW    = 2'd0,
    LVL_NORMAL = 2'd1,
    LVL_MID    = 2'd2,
    LVL_MAX    = 2'd3
  } level_t;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DOWN_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_UP_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_DOWN_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_UP_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DOWN_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_UP_LIMIT      = 3'd6;

  // Reset values of the limits, in millidegrees Celsius.
  localparam temp_t CRITICAL_LIMIT_RST    = 19'sd78000;
  localparam temp_t MAX_DOWN_LIMIT_RST    = 19'sd50000;
  localparam temp_t MID_UP_LIMIT_RST      = 19'sd57000;
  localparam temp_t MID_DOWN_LIMIT_RST    = 19'sd32000;
  localparam temp_t NORMAL_UP_LIMIT_RST   = 19'sd39000;
  localparam temp_t NORMAL_DOWN_LIMIT_RST = 19'sd0;
  localparam temp_t LOW_UP_LIMIT_RST      = 19'sd6000;

  localparam duty_t DUTY_FULL   = 7'd100;
  localparam duty_t DUTY_MID    = 7'd60;
  localparam duty_t DUTY_NORMAL = 7'd30;
  localparam duty_t DUTY_LOW_EVEN = 7'd40;
  localparam duty_t DUTY_OFF    = 7'd0;

  typedef struct packed {
    temp_t critical_limit;
    temp_t max_down_limit;
    temp_t mid_up_limit;
    temp_t mid_down_limit;
    temp_t normal_up_limit;
    temp_t normal_down_limit;
    temp_t low_up_limit;
  } limits_t;

  typedef struct packed {
    level_t level;
    logic   changed;
    logic   critical;
  } decision_t;

  function automatic duty_t duty_odd_of(level_t lvl);
    duty_t d;
    unique case (lvl)
      LVL_LOW:    d = DUTY_OFF;
      LVL_NORMAL: d = DUTY_NORMAL;
      LVL_MID:    d = DUTY_MID;
      LVL_MAX:    d = DUTY_FULL;
      default:    d = DUTY_FULL;
    endcase
    return d;
  endfunction

  function automatic duty_t duty_even_of(level_t lvl);
    duty_t d;
    unique case (lvl)
      LVL_LOW:    d = DUTY_LOW_EVEN;
      LVL_NORMAL: d = DUTY_NORMAL;
      LVL_MID:    d = DUTY_MID;
      LVL_MAX:    d = DUTY_FULL;
      default:    d = DUTY_FULL;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> design/tfdc_policy.sv
// Level policy: fault override and hysteresis stepping of the duty level for one poll.
`default_nettype none

module tfdc_policy #(
  parameter int FAN_COUNT = 4
) (
  input  wire tfdc_pkg::level_t  cur_level,
  input  wire tfdc_pkg::temp_t   temperature,
  input  wire tfdc_pkg::mask_t   fan_failed_mask,
  input  wire tfdc_pkg::mask_t   fan_present_mask,
  input  wire logic              read_error,
  input  wire tfdc_pkg::limits_t limits,
  output tfdc_pkg::decision_t    decision
);

  // Only fans that fit in the status masks are checked.
  localparam int CHK_N = (FAN_COUNT < tfdc_pkg::MASK_W) ? FAN_COUNT : tfdc_pkg::MASK_W;
  localparam tfdc_pkg::mask_t CHK_MASK = tfdc_pkg::mask_t'((1 << CHK_N) - 1);

  logic fault;

  assign fault = read_error || ((fan_failed_mask & CHK_MASK) != '0) ||
                 ((fan_present_mask & CHK_MASK) != CHK_MASK);

  always_comb begin
    decision.level    = cur_level;
    decision.changed  = 1'b0;
    decision.critical = 1'b0;
    if (fault) begin
      decision.level   = tfdc_pkg::LVL_MAX;
      decision.changed = 1'b1;
    end else begin
      unique case (cur_level)
        tfdc_pkg::LVL_MAX: begin
          if (temperature >= limits.critical_limit) begin
            decision.critical = 1'b1;
          end else if (temperature < limits.max_down_limit) begin
            decision.level   = tfdc_pkg::LVL_MID;
            decision.changed = 1'b1;
          end
        end
        tfdc_pkg::LVL_MID: begin
          if (temperature > limits.mid_up_limit) begin
            decision.level   = tfdc_pkg::LVL_MAX;
            decision.changed = 1'b1;
          end else if (temperature < limits.mid_down_limit) begin
            decision.level   = tfdc_pkg::LVL_NORMAL;
            decision.changed = 1'b1;
          end
        end
        tfdc_pkg::LVL_NORMAL: begin
          if (temperature > limits.normal_up_limit) begin
            decision.level   = tfdc_pkg::LVL_MID;
            decision.changed = 1'b1;
          end else if (temperature < limits.normal_down_limit) begin
            decision.level   = tfdc_pkg::LVL_LOW;
            decision.changed = 1'b1;
          end
        end
        tfdc_pkg::LVL_LOW: begin
          if (temperature > limits.low_up_limit) begin
            decision.level   = tfdc_pkg::LVL_NORMAL;
            decision.changed = 1'b1;
          end
        end
        default: begin
          decision.level = tfdc_pkg::LVL_MAX;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/thermal_fan_duty_controller.sv
// Top level of the thermal fan duty controller: input register, level policy, result register.
`default_nettype none

// The controller takes one poll per input transaction (temperature, fan failed
// and present masks, read error) and returns exactly one result transaction
// (level, odd and even fan duty, changed, critical) for each.
// Both channels use valid and stall; a transaction completes on a rising edge
// with valid high and stall low. The seven temperature limits are written on a
// plain write port (cfg_write, cfg_index, cfg_data); index seven is ignored.
// A poll is captured in the input register at its input transaction edge, and
// the compare-and-select policy then loads the result register, which raises
// out_valid; a stalled result can hold the poll in the input register meanwhile.
// Throughput is one transaction per cycle while out_stall is low; the duty level
// register loads in the same cycle as the result register, so the next poll sees it at once.
// When the receiver stalls, the result register holds, and one more poll can
// wait in the input register before in_stall rises.
// A synchronous reset empties both registers, sets the duty level to max and
// restores the limits to their default values.

module thermal_fan_duty_controller #(
  parameter int FAN_COUNT = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [tfdc_pkg::TEMP_W-1:0] temperature,
  input  wire logic [tfdc_pkg::MASK_W-1:0]      fan_failed_mask,
  input  wire logic [tfdc_pkg::MASK_W-1:0]      fan_present_mask,
  input  wire logic                             read_error,
  // Output channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            level,
  output logic [tfdc_pkg::DUTY_W-1:0]           duty_odd,
  output logic [tfdc_pkg::DUTY_W-1:0]           duty_even,
  output logic                                  changed,
  output logic                                  critical,
  // Configuration write port.
  input  wire logic                             cfg_write,
  input  wire logic [tfdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tfdc_pkg::TEMP_W-1:0]      cfg_data
);

  tfdc_pkg::limits_t   limits;
  tfdc_pkg::level_t    duty_level;
  tfdc_pkg::decision_t decision;

  // Input register.
  logic              s1_valid;
  tfdc_pkg::temp_t   s1_temperature;
  tfdc_pkg::mask_t   s1_failed;
  tfdc_pkg::mask_t   s1_present;
  logic              s1_read_error;

  logic advance;

  // The result register can take a new value when it is empty or being drained.
  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.critical_limit    <= tfdc_pkg::CRITICAL_LIMIT_RST;
      limits.max_down_limit    <= tfdc_pkg::MAX_DOWN_LIMIT_RST;
      limits.mid_up_limit      <= tfdc_pkg::MID_UP_LIMIT_RST;
      limits.mid_down_limit    <= tfdc_pkg::MID_DOWN_LIMIT_RST;
      limits.normal_up_limit   <= tfdc_pkg::NORMAL_UP_LIMIT_RST;
      limits.normal_down_limit <= tfdc_pkg::NORMAL_DOWN_LIMIT_RST;
      limits.low_up_limit      <= tfdc_pkg::LOW_UP_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tfdc_pkg::REG_CRITICAL_LIMIT:    limits.critical_limit    <= cfg_data;
        tfdc_pkg::REG_MAX_DOWN_LIMIT:    limits.max_down_limit    <= cfg_data;
        tfdc_pkg::REG_MID_UP_LIMIT:      limits.mid_up_limit      <= cfg_data;
        tfdc_pkg::REG_MID_DOWN_LIMIT:    limits.mid_down_limit    <= cfg_data;
        tfdc_pkg::REG_NORMAL_UP_LIMIT:   limits.normal_up_limit   <= cfg_data;
        tfdc_pkg::REG_NORMAL_DOWN_LIMIT: limits.normal_down_limit <= cfg_data;
        tfdc_pkg::REG_LOW_UP_LIMIT:      limits.low_up_limit      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: loads whenever it is not held by a stalled result.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_temperature <= temperature;
      s1_failed      <= fan_failed_mask;
      s1_present     <= fan_present_mask;
      s1_read_error  <= read_error;
    end
  end

  tfdc_policy #(
    .FAN_COUNT (FAN_COUNT)
  ) u_policy (
    .cur_level        (duty_level),
    .temperature      (s1_temperature),
    .fan_failed_mask  (s1_failed),
    .fan_present_mask (s1_present),
    .read_error       (s1_read_error),
    .limits           (limits),
    .decision         (decision)
  );

  // Duty level state moves with each poll that reaches the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_level <= tfdc_pkg::LVL_MAX;
    end else if (advance) begin
      duty_level <= decision.level;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level     <= decision.level;
      duty_odd  <= tfdc_pkg::duty_odd_of(decision.level);
      duty_even <= tfdc_pkg::duty_even_of(decision.level);
      changed   <= decision.changed;
      critical  <= decision.critical;
    end
  end

endmodule

`default_nettype wire

>>> bench/tfdc_checker.sv
// Checker for the thermal fan duty controller: predicts each poll's result and compares it.
`default_nettype none

module tfdc_checker
  import tfdc_pkg::*;
#(
  parameter int FAN_COUNT = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire temp_t                temperature,
  input  wire mask_t                fan_failed_mask,
  input  wire mask_t                fan_present_mask,
  input  wire logic                 read_error,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [1:0]           level,
  input  wire duty_t                duty_odd,
  input  wire duty_t                duty_even,
  input  wire logic                 changed,
  input  wire logic                 critical,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire temp_t                cfg_data,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    level_t lvl;
    duty_t  odd;
    duty_t  even;
    logic   changed;
    logic   critical;
  } fan_result_t;

  fan_result_t expected_results[$];
  temp_t       limit_regs[0:6];
  level_t      duty_state;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Works out the next level from the current one, then the duties that go with it.
  function automatic fan_result_t predict_poll(temp_t t, mask_t failed, mask_t present,
                                               logic rd_err);
    fan_result_t r;
    mask_t       watched;
    watched    = '0;
    for (int i = 0; i < FAN_COUNT && i < MASK_W; i++) watched[i] = 1'b1;
    r.lvl      = duty_state;
    r.changed  = 1'b0;
    r.critical = 1'b0;
    if (rd_err || (failed & watched) != '0 || (present & watched) != watched) begin
      r.lvl     = LVL_MAX;
      r.changed = 1'b1;
    end else begin
      case (duty_state)
        LVL_MAX: begin
          if (t >= limit_regs[REG_CRITICAL_LIMIT]) begin
            r.critical = 1'b1;
          end else if (t < limit_regs[REG_MAX_DOWN_LIMIT]) begin
            r.lvl     = LVL_MID;
            r.changed = 1'b1;
          end
        end
        LVL_MID: begin
          if (t > limit_regs[REG_MID_UP_LIMIT]) begin
            r.lvl     = LVL_MAX;
            r.changed = 1'b1;
          end else if (t < limit_regs[REG_MID_DOWN_LIMIT]) begin
            r.lvl     = LVL_NORMAL;
            r.changed = 1'b1;
          end
        end
        LVL_NORMAL: begin
          if (t > limit_regs[REG_NORMAL_UP_LIMIT]) begin
            r.lvl     = LVL_MID;
            r.changed = 1'b1;
          end else if (t < limit_regs[REG_NORMAL_DOWN_LIMIT]) begin
            r.lvl     = LVL_LOW;
            r.changed = 1'b1;
          end
        end
        default: begin
          if (t > limit_regs[REG_LOW_UP_LIMIT]) begin
            r.lvl     = LVL_NORMAL;
            r.changed = 1'b1;
          end
        end
      endcase
    end
    case (r.lvl)
      LVL_LOW: begin
        r.odd  = DUTY_OFF;
        r.even = DUTY_LOW_EVEN;
      end
      LVL_NORMAL: begin
        r.odd  = DUTY_NORMAL;
        r.even = DUTY_NORMAL;
      end
      LVL_MID: begin
        r.odd  = DUTY_MID;
        r.even = DUTY_MID;
      end
      default: begin
        r.odd  = DUTY_FULL;
        r.even = DUTY_FULL;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    fan_result_t want;
    fan_result_t got;
    if (rst) begin
      limit_regs[REG_CRITICAL_LIMIT]    = CRITICAL_LIMIT_RST;
      limit_regs[REG_MAX_DOWN_LIMIT]    = MAX_DOWN_LIMIT_RST;
      limit_regs[REG_MID_UP_LIMIT]      = MID_UP_LIMIT_RST;
      limit_regs[REG_MID_DOWN_LIMIT]    = MID_DOWN_LIMIT_RST;
      limit_regs[REG_NORMAL_UP_LIMIT]   = NORMAL_UP_LIMIT_RST;
      limit_regs[REG_NORMAL_DOWN_LIMIT] = NORMAL_DOWN_LIMIT_RST;
      limit_regs[REG_LOW_UP_LIMIT]      = LOW_UP_LIMIT_RST;
      duty_state = LVL_MAX;
      expected_results.delete();
    end else begin
      // Writes to an index past the last limit do nothing.
      if (cfg_write && cfg_index <= REG_LOW_UP_LIMIT) limit_regs[cfg_index] = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no poll waiting: level %0d", level);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (level !== want.lvl) begin
            $error("level: expected %0d, actual %0d", want.lvl, level);
            fail_count++;
          end
          if (duty_odd !== want.odd) begin
            $error("duty_odd: expected %0d, actual %0d", want.odd, duty_odd);
            fail_count++;
          end
          if (duty_even !== want.even) begin
            $error("duty_even: expected %0d, actual %0d", want.even, duty_even);
            fail_count++;
          end
          if (changed !== want.changed) begin
            $error("changed: expected %0d, actual %0d", want.changed, changed);
            fail_count++;
          end
          if (critical !== want.critical) begin
            $error("critical: expected %0d, actual %0d", want.critical, critical);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        got = predict_poll(temperature, fan_failed_mask, fan_present_mask, read_error);
        duty_state = got.lvl;
        expected_results.push_back(got);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Testbench top for the thermal fan duty controller: stimulus, idling, watchdog and verdict.
`default_nettype none

module tb;
  import tfdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FANS = 4;
  // Cycles without any transaction or register write before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TEMP_MIN = -50000;
  localparam int TEMP_MAX = 150000;
  // The configuration port decodes one index past the last limit; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam mask_t ALL_PRESENT = 4'hF;
  localparam mask_t NONE_FAILED = 4'h0;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  temp_t                temperature = '0;
  mask_t                fan_failed_mask = '0;
  mask_t                fan_present_mask = '0;
  logic                 read_error = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           level;
  duty_t                duty_odd;
  duty_t                duty_even;
  logic                 changed;
  logic                 critical;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  temp_t                cfg_data = '0;

  int fail_count;
  int outstanding;
  int quiet_cycles = 0;
  // Percent chance per opportunity that the sender or the receiver starts an idle burst.
  int gap_pct = 0;
  int stall_pct = 0;
  limits_t cur_lim;

  thermal_fan_duty_controller #(.FAN_COUNT(FANS)) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temperature      (temperature),
    .fan_failed_mask  (fan_failed_mask),
    .fan_present_mask (fan_present_mask),
    .read_error       (read_error),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .level            (level),
    .duty_odd         (duty_odd),
    .duty_even        (duty_even),
    .changed          (changed),
    .critical         (critical),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  tfdc_checker #(.FAN_COUNT(FANS)) u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temperature      (temperature),
    .fan_failed_mask  (fan_failed_mask),
    .fan_present_mask (fan_present_mask),
    .read_error       (read_error),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .level            (level),
    .duty_odd         (duty_odd),
    .duty_even        (duty_even),
    .changed          (changed),
    .critical         (critical),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls in bursts of random length. The burst length is drawn when the
  // burst starts, so a burst that is under way finishes even after idling is switched off.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(16);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Any transaction on either channel, or a register write, counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one poll and returns at the edge where it is accepted. A sender gap, when one
  // is drawn, drops valid first; otherwise valid stays high into the next transaction.
  task automatic send_poll(input temp_t t, input mask_t failed, input mask_t present,
                           input logic rd_err);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    temperature      <= t;
    fan_failed_mask  <= failed;
    fan_present_mask <= present;
    read_error       <= rd_err;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A poll with every fan present and healthy and a clean read, so only the temperature
  // decides the level.
  task automatic send_healthy(input int t);
    send_poll(temp_t'(t), NONE_FAILED, ALL_PRESENT, 1'b0);
  endtask

  // Stops sending and waits until every predicted result has been delivered. The first
  // edge lets the checker register a poll accepted at the edge just passed.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes all seven limits, then a junk value to the unused index, which must not land
  // anywhere. Only called with nothing in flight.
  task automatic load_limits(input limits_t lim);
    temp_t vals[7];
    logic [CFG_IDX_W-1:0] idx[7];
    vals = '{lim.critical_limit, lim.max_down_limit, lim.mid_up_limit, lim.mid_down_limit,
             lim.normal_up_limit, lim.normal_down_limit, lim.low_up_limit};
    idx  = '{REG_CRITICAL_LIMIT, REG_MAX_DOWN_LIMIT, REG_MID_UP_LIMIT, REG_MID_DOWN_LIMIT,
             REG_NORMAL_UP_LIMIT, REG_NORMAL_DOWN_LIMIT, REG_LOW_UP_LIMIT};
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_index <= REG_UNUSED;
    cfg_data  <= temp_t'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic temp_t any_temp();
    return temp_t'(int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
  endfunction

  // Most temperatures sit within a couple of millidegrees of some limit, so the strict and
  // inclusive comparisons are both hit; the rest are extremes or spread over the range.
  function automatic temp_t pick_temp(input limits_t lim);
    temp_t near[7];
    int    v;
    near = '{lim.critical_limit, lim.max_down_limit, lim.mid_up_limit, lim.mid_down_limit,
             lim.normal_up_limit, lim.normal_down_limit, lim.low_up_limit};
    case ($urandom_range(9))
      0:       v = TEMP_MIN;
      1:       v = TEMP_MAX;
      2, 3:    v = int'(any_temp());
      default: v = int'(near[$urandom_range(6)]) + int'($urandom_range(4)) - 2;
    endcase
    if (v < TEMP_MIN) v = TEMP_MIN;
    if (v > TEMP_MAX) v = TEMP_MAX;
    return temp_t'(v);
  endfunction

  // A ladder of limits in the intended order, with random spacing, so that polls near
  // the limits walk the level through every step.
  function automatic limits_t ordered_limits();
    limits_t lim;
    int b;
    b = int'($urandom_range(100000)) - 40000;
    lim.low_up_limit      = temp_t'(b);
    lim.normal_down_limit = temp_t'(b - int'($urandom_range(6000)));
    lim.normal_up_limit   = temp_t'(b + int'($urandom_range(30000)));
    lim.mid_down_limit    = temp_t'(int'(lim.normal_up_limit) - int'($urandom_range(10000)));
    lim.mid_up_limit      = temp_t'(int'(lim.normal_up_limit) + int'($urandom_range(25000)));
    lim.max_down_limit    = temp_t'(int'(lim.mid_up_limit) - int'($urandom_range(10000)));
    lim.critical_limit    = temp_t'(int'(lim.mid_up_limit) + int'($urandom_range(25000)));
    return lim;
  endfunction

  initial begin
    limits_t defaults;
    limits_t lim;
    mask_t   failed;
    mask_t   present;
    logic    rd_err;

    defaults.critical_limit    = CRITICAL_LIMIT_RST;
    defaults.max_down_limit    = MAX_DOWN_LIMIT_RST;
    defaults.mid_up_limit      = MID_UP_LIMIT_RST;
    defaults.mid_down_limit    = MID_DOWN_LIMIT_RST;
    defaults.normal_up_limit   = NORMAL_UP_LIMIT_RST;
    defaults.normal_down_limit = NORMAL_DOWN_LIMIT_RST;
    defaults.low_up_limit      = LOW_UP_LIMIT_RST;
    cur_lim = defaults;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk on the reset limits. The level starts at max, so the first polls
    // check the critical alarm and its inclusive edge, then the level is stepped down
    // and up across every limit, with the hold cases right on each limit.
    stall_pct = 20;
    send_healthy(78000);
    send_healthy(TEMP_MAX);
    send_healthy(50000);
    send_healthy(49999);
    send_healthy(57000);
    send_healthy(57001);
    send_healthy(32000);
    send_healthy(32000);
    send_healthy(31999);
    send_healthy(39000);
    send_healthy(39001);
    send_healthy(TEMP_MIN);
    send_healthy(0);
    send_healthy(-1);
    // Low must hold, even at the coldest reading, until the temperature climbs past
    // its up limit.
    send_healthy(6000);
    send_healthy(TEMP_MIN);
    send_healthy(6001);
    send_healthy(TEMP_MIN);
    // Forced max, first from low: a read error with clean masks, then a failed fan, then a
    // missing fan, each time stepping back down to mid in between.
    send_poll(temp_t'(TEMP_MIN), NONE_FAILED, ALL_PRESENT, 1'b1);
    send_healthy(TEMP_MIN);
    send_poll(temp_t'(TEMP_MIN), 4'b1000, ALL_PRESENT, 1'b0);
    send_healthy(TEMP_MIN);
    send_poll(temp_t'(TEMP_MIN), NONE_FAILED, 4'b0111, 1'b0);
    // A forced max never raises the alarm, even at the hottest reading.
    send_poll(temp_t'(TEMP_MAX), 4'hF, 4'h0, 1'b1);
    send_healthy(TEMP_MAX);
    drain();

    // Random phases, each on its own set of limits. Every phase starts and ends with the
    // block idle, since the limits are only rewritten with nothing in flight.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          lim = defaults;
          gap_pct = 30;
          stall_pct = 30;
        end
        1: begin
          // Every limit at the bottom of the range.
          lim = '{default: temp_t'(TEMP_MIN)};
          gap_pct = 0;
          stall_pct = 0;
        end
        2: begin
          // Every limit at the top of the range.
          lim = '{default: temp_t'(TEMP_MAX)};
          gap_pct = 10;
          stall_pct = 50;
        end
        3: begin
          lim = ordered_limits();
          gap_pct = 50;
          stall_pct = 10;
        end
        4: begin
          // Limits drawn independently, so some of them cross each other.
          lim.critical_limit    = any_temp();
          lim.max_down_limit    = any_temp();
          lim.mid_up_limit      = any_temp();
          lim.mid_down_limit    = any_temp();
          lim.normal_up_limit   = any_temp();
          lim.normal_down_limit = any_temp();
          lim.low_up_limit      = any_temp();
          gap_pct = 20;
          stall_pct = 20;
        end
        5: begin
          // The alarm limit below the step-down limit: at max, a reading between them
          // must raise the alarm and keep the level rather than step down.
          lim = ordered_limits();
          lim.critical_limit = temp_t'(int'($urandom_range(30000)) - 20000);
          lim.max_down_limit = temp_t'(int'($urandom_range(40000)) + 60000);
          gap_pct = 5;
          stall_pct = 70;
        end
        default: begin
          // Closing phase: back to the defaults and no idling on either side.
          lim = defaults;
          gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      cur_lim = lim;
      load_limits(cur_lim);
      for (int n = 0; n < 250; n++) begin
        // Mostly healthy polls so the hysteresis gets exercised; the rest is noise on
        // the masks and the read error flag, which mostly forces max.
        if ($urandom_range(99) < 85) begin
          failed  = NONE_FAILED;
          present = ALL_PRESENT;
          rd_err  = 1'b0;
        end else begin
          failed  = mask_t'($urandom_range(15));
          present = mask_t'($urandom_range(15));
          rd_err  = 1'($urandom_range(1));
        end
        send_poll(pick_temp(cur_lim), failed, present, rd_err);
        // Now and then the sender holds off until the block has emptied.
        if (gap_pct != 0 && $urandom_range(99) == 0) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/tfdc_pkg.sv
design/tfdc_policy.sv
design/thermal_fan_duty_controller.sv
bench/tfdc_checker.sv
bench/tb.sv
